// File: rtl/srtc_pkg.sv
// Shared types, constants and helpers for the signed radix-to-text converter.
// Used by srtc_front, srtc_queue, srtc_back and the top level; no dependencies.
package srtc_pkg;

  // Sizing
  localparam int MAX_SYMBOLS  = 32;
  localparam int VALUE_WIDTH  = 32;
  localparam int LEN_W        = 6;
  localparam int WORD_W       = 64;
  localparam int NUM_WORDS    = 4;
  localparam int SYM_W        = 8;
  localparam int ALPHA_W      = NUM_WORDS * WORD_W;
  localparam int SEEN_W       = 2 ** (SYM_W - 1);
  localparam int DIGIT_W      = $clog2(MAX_SYMBOLS);
  localparam int TRIAL_W      = DIGIT_W + 1;
  localparam int STORE_DEPTH  = VALUE_WIDTH;
  localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
  localparam int COUNT_W      = $clog2(STORE_DEPTH + 1);

  // Divider: STEP_BITS quotient bits per cycle
  localparam int STEP_BITS    = 8;
  localparam int DIV_CYCLES   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W        = DIV_CYCLES * STEP_BITS;
  localparam int STEP_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Job queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W    = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_3 = 3'd4;

  // Special characters
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  // Classified conversion job handed from front to back
  typedef struct packed {
    logic                   bad;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } srtc_job_t;

  // Symbol idx of the packed alphabet, symbol 0 in the low byte
  function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0]  alpha,
                                              input logic [DIGIT_W-1:0]  idx);
    return alpha[idx * SYM_W +: SYM_W];
  endfunction

endpackage

// File: rtl/srtc_front.sv
// Front end: accepts numbers, forms sign and magnitude, and checks the alphabet
// one symbol per cycle before handing a job to the queue. Depends on srtc_pkg.
module srtc_front import srtc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [VALUE_WIDTH-1:0] number,
  output logic                          full,
  input  logic [ALPHA_W-1:0]            alphabet,
  input  logic [LEN_W-1:0]              alphabet_length,
  output srtc_job_t                     job,
  output logic                          job_push,
  input  logic                          queue_full
);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_CHECK = 3'b010,
    F_PUSH  = 3'b100
  } front_state_t;

  front_state_t           state, state_next;
  logic [DIGIT_W-1:0]     idx;
  logic [SEEN_W-1:0]      seen;
  logic [SYM_W-1:0]       sym;
  logic                   sym_bad;
  logic                   last_sym;
  logic                   len_bad;
  logic [VALUE_WIDTH-1:0] num_u;
  logic                   num_neg;
  logic [VALUE_WIDTH-1:0] num_mag;

  // Sign and magnitude; the most negative value maps to its full magnitude
  assign num_u   = number;
  assign num_neg = num_u[VALUE_WIDTH-1];
  assign num_mag = num_neg ? (~num_u + VALUE_WIDTH'(1)) : num_u;

  // Alphabet checks
  assign len_bad  = (alphabet_length < LEN_W'(2)) ||
                    (alphabet_length > LEN_W'(MAX_SYMBOLS));
  assign sym      = sym_at(alphabet, idx);
  assign sym_bad  = (sym == '0) || sym[SYM_W-1] || (sym == SYM_PLUS) ||
                    (sym == SYM_MINUS) || seen[sym[SYM_W-2:0]];
  assign last_sym = ({1'b0, idx} == (alphabet_length - LEN_W'(1)));

  assign full     = (state != F_IDLE);
  assign job_push = (state == F_PUSH) && !queue_full;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (push) state_next = len_bad ? F_PUSH : F_CHECK;
      end
      F_CHECK: begin
        if (sym_bad || last_sym) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!queue_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Job payload and check sweep
  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (push) begin
          job.neg <= num_neg;
          job.mag <= num_mag;
          job.bad <= len_bad;
          idx     <= '0;
          seen    <= '0;
        end
      end
      F_CHECK: begin
        if (sym_bad) begin
          job.bad <= 1'b1;
        end else begin
          seen[sym[SYM_W-2:0]] <= 1'b1;
          idx                  <= idx + DIGIT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/srtc_queue.sv
// Short job queue between front and back end, built from flops.
// Depends on srtc_pkg for the job type and depth.
module srtc_queue import srtc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  srtc_job_t push_job,
  output logic      full,
  input  logic      pop,
  output srtc_job_t pop_job,
  output logic      empty
);

  srtc_job_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

endmodule

// File: rtl/srtc_back.sv
// Back end: divides the magnitude by the radix, STEP_BITS quotient bits per
// cycle, stacks digits, emits sign and symbols or bad_base. Uses srtc_pkg.
module srtc_back import srtc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  srtc_job_t          job,
  input  logic               queue_empty,
  output logic               queue_pop,
  input  logic [ALPHA_W-1:0] alphabet,
  input  logic [LEN_W-1:0]   alphabet_length,
  input  logic               pop,
  output logic               empty,
  output logic [SYM_W-1:0]   symbol,
  output logic               last,
  output logic               bad_base
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_DIV   = 5'b00010,
    B_SIGN  = 5'b00100,
    B_DIGIT = 5'b01000,
    B_BAD   = 5'b10000
  } back_state_t;

  back_state_t             state, state_next;
  logic [DIV_W-1:0]        quot;
  logic [DIGIT_W-1:0]      rem;
  logic [STEP_CNT_W-1:0]   step;
  logic [COUNT_W-1:0]      count;
  logic                    neg;
  logic [DIGIT_W-1:0]      digit_store [STORE_DEPTH];
  logic                    out_valid;

  logic [DIV_W-1:0]        quot_v;
  logic [DIGIT_W-1:0]      rem_v;
  logic [TRIAL_W-1:0]      trial;
  logic [TRIAL_W-1:0]      radix;
  logic                    div_done;
  logic [COUNT_W-1:0]      count_inc;
  logic [COUNT_W-1:0]      digit_idx;
  logic [DIGIT_W-1:0]      rd_digit;
  logic                    more;
  logic                    out_free;
  logic                    out_load;
  logic [SYM_W-1:0]        out_sym;
  logic                    out_last;
  logic                    out_bad;

  assign radix = TRIAL_W'(alphabet_length);

  // STEP_BITS restoring steps on the narrow partial remainder
  always_comb begin
    quot_v = quot;
    rem_v  = rem;
    trial  = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      trial  = {rem_v, quot_v[DIV_W-1]};
      quot_v = {quot_v[DIV_W-2:0], 1'b0};
      if (trial >= radix) begin
        trial     = trial - radix;
        quot_v[0] = 1'b1;
      end
      rem_v = trial[DIGIT_W-1:0];
    end
  end

  assign div_done  = (step == STEP_CNT_W'(DIV_CYCLES - 1));
  assign count_inc = count + COUNT_W'(1);
  assign more      = (quot_v != '0) && (count_inc < COUNT_W'(STORE_DEPTH));
  assign digit_idx = count - COUNT_W'(1);
  assign rd_digit  = digit_store[digit_idx[STORE_IDX_W-1:0]];

  // Output register handshake
  assign out_free  = !out_valid || pop;
  assign out_load  = out_free &&
                     ((state == B_SIGN) || (state == B_DIGIT) || (state == B_BAD));
  assign empty     = !out_valid;
  assign queue_pop = (state == B_IDLE) && !queue_empty;

  // Next result
  always_comb begin
    out_sym  = '0;
    out_last = 1'b0;
    out_bad  = 1'b0;
    unique case (state)
      B_SIGN: begin
        out_sym = SYM_MINUS;
      end
      B_DIGIT: begin
        out_sym  = sym_at(alphabet, rd_digit);
        out_last = (count == COUNT_W'(1));
      end
      B_BAD: begin
        out_last = 1'b1;
        out_bad  = 1'b1;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!queue_empty) state_next = job.bad ? B_BAD : B_DIV;
      end
      B_DIV: begin
        if (div_done && !more) state_next = neg ? B_SIGN : B_DIGIT;
      end
      B_SIGN: begin
        if (out_free) state_next = B_DIGIT;
      end
      B_DIGIT: begin
        if (out_free && (count == COUNT_W'(1))) state_next = B_IDLE;
      end
      B_BAD: begin
        if (out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Division, digit stack and emit counter
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!queue_empty) begin
          quot  <= DIV_W'(job.mag);
          rem   <= '0;
          step  <= '0;
          count <= '0;
          neg   <= job.neg;
        end
      end
      B_DIV: begin
        quot <= quot_v;
        if (div_done) begin
          digit_store[count[STORE_IDX_W-1:0]] <= rem_v;
          count <= count_inc;
          rem   <= '0;
          step  <= '0;
        end else begin
          rem  <= rem_v;
          step <= step + STEP_CNT_W'(1);
        end
      end
      B_DIGIT: begin
        if (out_free) count <= digit_idx;
      end
      default: ;
    endcase
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      symbol   <= out_sym;
      last     <= out_last;
      bad_base <= out_bad;
    end
  end

endmodule

// File: rtl/signed_radix_to_text_converter_top.sv
// Signed radix-to-text converter, top level: config registers, front, queue, back.
// The back end converts one job at a time with an 8-bit-per-cycle divider and
// emits one symbol per digit, plus one for a sign; the front's alphabet sweep
// overlaps the back end.
// Reset (rst, synchronous): registers to zero, queue and output empty.
module signed_radix_to_text_converter_top import srtc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [VALUE_WIDTH-1:0] number,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output logic [SYM_W-1:0]              symbol,
  output logic                          last,
  output logic                          bad_base,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [WORD_W-1:0]             cfg_data
);

  logic [LEN_W-1:0]                  alphabet_length;
  logic [NUM_WORDS-1:0][WORD_W-1:0]  alphabet_word;
  logic [ALPHA_W-1:0]                alphabet;
  srtc_job_t                         front_job, back_job;
  logic                              job_push, queue_full, queue_pop, queue_empty;

  assign alphabet = alphabet_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_length <= '0;
      alphabet_word   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LENGTH: alphabet_length  <= cfg_data[LEN_W-1:0];
        REG_WORD_0: alphabet_word[0] <= cfg_data;
        REG_WORD_1: alphabet_word[1] <= cfg_data;
        REG_WORD_2: alphabet_word[2] <= cfg_data;
        REG_WORD_3: alphabet_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  srtc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .number          (number),
    .full            (full),
    .alphabet        (alphabet),
    .alphabet_length (alphabet_length),
    .job             (front_job),
    .job_push        (job_push),
    .queue_full      (queue_full)
  );

  srtc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .full     (queue_full),
    .pop      (queue_pop),
    .pop_job  (back_job),
    .empty    (queue_empty)
  );

  srtc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job             (back_job),
    .queue_empty     (queue_empty),
    .queue_pop       (queue_pop),
    .alphabet        (alphabet),
    .alphabet_length (alphabet_length),
    .pop             (pop),
    .empty           (empty),
    .symbol          (symbol),
    .last            (last),
    .bad_base        (bad_base)
  );

endmodule
